// File: rtl/assert_macros.svh
// assertion helpers for the circle fit block
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, quiet while reset is high
`define AST_RST(name, ck, rs, prop, msg) \
  name: assert property (@(posedge ck) disable iff (rs) prop) else $error(msg);

// clocked check with no reset gating
`define AST_ON(name, ck, prop, msg) \
  name: assert property (@(posedge ck) prop) else $error(msg);

`endif

// File: rtl/tpcf_pkg.sv
`default_nettype none
package tpcf_pkg;

  // field sizes
  localparam int COORD_BITS = 12;
  localparam int FRAC_BITS  = 4;
  localparam int IN_W       = 12;
  localparam int OUT_W      = 20;

  // datapath widths
  localparam int DIF_W  = COORD_BITS + 1;
  localparam int DET_W  = 2 * COORD_BITS + 2;
  localparam int SS_W   = 2 * COORD_BITS + 1;
  localparam int ADET_W = 2 * COORD_BITS + 1;
  localparam int NX_W   = 3 * COORD_BITS + 3;
  localparam int ANX_W  = 3 * COORD_BITS + 2;
  localparam int CD_W   = ANX_W + FRAC_BITS + 1;
  localparam int CE_W   = ADET_W + 1;
  localparam int P_W    = 2 * SS_W;
  localparam int PL_W   = P_W / 2;
  localparam int PH_W   = P_W - PL_W;
  localparam int ML_W   = PL_W + SS_W;
  localparam int MH_W   = PH_W + SS_W;
  localparam int X_W    = P_W + SS_W + 2 * FRAC_BITS;
  localparam int D2_W   = 2 * ADET_W;

  // quotient and root widths
  localparam int QC_W = ((COORD_BITS + FRAC_BITS > OUT_W - 1) ?
                         COORD_BITS + FRAC_BITS : OUT_W - 1) + 1;
  localparam int QR_W = 2 * (OUT_W + 1);
  localparam int SR_W = OUT_W + 1;

  // unit latencies
  localparam int FRONT    = 7;
  localparam int CDIV_LAT = QC_W + 1;
  localparam int RAD_LAT  = QR_W + SR_W + 2;
  localparam int CDLY     = RAD_LAT - CDIV_LAT;

  typedef enum logic [1:0] {
    ST_OK,
    ST_COINCIDE,
    ST_COLLINEAR,
    ST_SATURATED
  } fit_status_t;

endpackage
`default_nettype wire

// File: rtl/tpcf_if.sv
`default_nettype none
// point triple request channel
interface tpcf_pt_if;
  logic                       valid;
  logic                       ready;
  logic [tpcf_pkg::IN_W-1:0]  point_a_x;
  logic [tpcf_pkg::IN_W-1:0]  point_a_y;
  logic [tpcf_pkg::IN_W-1:0]  point_b_x;
  logic [tpcf_pkg::IN_W-1:0]  point_b_y;
  logic [tpcf_pkg::IN_W-1:0]  point_c_x;
  logic [tpcf_pkg::IN_W-1:0]  point_c_y;
  modport source (output valid, point_a_x, point_a_y, point_b_x, point_b_y,
                  point_c_x, point_c_y, input ready);
  modport sink (input valid, point_a_x, point_a_y, point_b_x, point_b_y,
                point_c_x, point_c_y, output ready);
endinterface

// circle result channel
interface tpcf_res_if;
  logic                               valid;
  logic                               ready;
  logic signed [tpcf_pkg::OUT_W-1:0]  center_x;
  logic signed [tpcf_pkg::OUT_W-1:0]  center_y;
  logic [tpcf_pkg::OUT_W-1:0]         circle_radius;
  tpcf_pkg::fit_status_t              fit_status;
  modport source (output valid, center_x, center_y, circle_radius, fit_status,
                  input ready);
  modport sink (input valid, center_x, center_y, circle_radius, fit_status,
                output ready);
endinterface
`default_nettype wire

// File: rtl/tpcf_cdiv.sv
`default_nettype none
// pipelined restoring divide, one quotient bit per stage
module tpcf_cdiv (
  input  logic                          clk,
  input  logic                          en,
  input  logic [tpcf_pkg::CD_W-1:0]     num,
  input  logic [tpcf_pkg::CE_W-1:0]     den,
  output logic [tpcf_pkg::QC_W-1:0]     quo,
  output logic                          ovf
);
  localparam int CD_W  = tpcf_pkg::CD_W;
  localparam int CE_W  = tpcf_pkg::CE_W;
  localparam int QC_W  = tpcf_pkg::QC_W;
  localparam int CMP_W = CD_W + QC_W;

  logic [CD_W-1:0] rem_s [QC_W+1];
  logic [CE_W-1:0] den_s [QC_W+1];
  logic [QC_W-1:0] quo_s [QC_W+1];
  logic            ovf_s [QC_W+1];

  // entry stage: flag quotients too large for the field
  always_ff @(posedge clk) begin
    if (en) begin
      rem_s[0] <= num;
      den_s[0] <= den;
      quo_s[0] <= '0;
      ovf_s[0] <= CMP_W'(num) >= (CMP_W'(den) << QC_W);
    end
  end

  // one trial subtract per stage, msb first
  for (genvar i = 0; i < QC_W; i++) begin : g_step
    localparam int SH = QC_W - 1 - i;
    logic [CMP_W-1:0] trial;
    logic             take;
    assign trial = CMP_W'(den_s[i]) << SH;
    assign take  = CMP_W'(rem_s[i]) >= trial;
    always_ff @(posedge clk) begin
      if (en) begin
        rem_s[i+1] <= take ? CD_W'(CMP_W'(rem_s[i]) - trial) : rem_s[i];
        den_s[i+1] <= den_s[i];
        quo_s[i+1] <= {quo_s[i][QC_W-2:0], take};
        ovf_s[i+1] <= ovf_s[i];
      end
    end
  end

  assign quo = quo_s[QC_W];
  assign ovf = ovf_s[QC_W];
endmodule
`default_nettype wire

// File: rtl/tpcf_rad.sv
`default_nettype none
// radius unit: q = floor(x / det2), root of q, then half-odd rounding
module tpcf_rad (
  input  logic                          clk,
  input  logic                          en,
  input  logic [tpcf_pkg::X_W-1:0]      x,
  input  logic [tpcf_pkg::D2_W-1:0]     det2,
  output logic [tpcf_pkg::OUT_W-1:0]    radius,
  output logic                          sat
);
  localparam int X_W   = tpcf_pkg::X_W;
  localparam int D2_W  = tpcf_pkg::D2_W;
  localparam int QR_W  = tpcf_pkg::QR_W;
  localparam int SR_W  = tpcf_pkg::SR_W;
  localparam int OUT_W = tpcf_pkg::OUT_W;
  localparam int CMP_W = X_W + QR_W;
  localparam int SQ1_W = QR_W + 1;

  logic [X_W-1:0]  rem_s [QR_W+1];
  logic [D2_W-1:0] den_s [QR_W+1];
  logic [QR_W-1:0] quo_s [QR_W+1];
  logic            dovf_s [QR_W+1];

  logic [QR_W-1:0] num_s [SR_W+1];
  logic [QR_W-1:0] res_s [SR_W+1];
  logic            sovf_s [SR_W+1];

  logic [SR_W-1:0] half_k;

  // entry stage: a quotient past the field means saturation
  always_ff @(posedge clk) begin
    if (en) begin
      rem_s[0]  <= x;
      den_s[0]  <= det2;
      quo_s[0]  <= '0;
      dovf_s[0] <= CMP_W'(x) >= (CMP_W'(det2) << QR_W);
    end
  end

  // divide stages
  for (genvar i = 0; i < QR_W; i++) begin : g_div
    localparam int SH = QR_W - 1 - i;
    logic [CMP_W-1:0] trial;
    logic             take;
    assign trial = CMP_W'(den_s[i]) << SH;
    assign take  = CMP_W'(rem_s[i]) >= trial;
    always_ff @(posedge clk) begin
      if (en) begin
        rem_s[i+1]  <= take ? X_W'(CMP_W'(rem_s[i]) - trial) : rem_s[i];
        den_s[i+1]  <= den_s[i];
        quo_s[i+1]  <= {quo_s[i][QR_W-2:0], take};
        dovf_s[i+1] <= dovf_s[i];
      end
    end
  end

  // hand quotient to the root stages
  assign num_s[0]  = quo_s[QR_W];
  assign res_s[0]  = '0;
  assign sovf_s[0] = dovf_s[QR_W];

  // integer square root, one root bit per stage
  for (genvar i = 0; i < SR_W; i++) begin : g_sqrt
    localparam int BP = 2 * (SR_W - 1 - i);
    logic [SQ1_W-1:0] bitv;
    logic [SQ1_W-1:0] trial;
    logic             take;
    assign bitv  = SQ1_W'(1) << BP;
    assign trial = SQ1_W'(res_s[i]) + bitv;
    assign take  = SQ1_W'(num_s[i]) >= trial;
    always_ff @(posedge clk) begin
      if (en) begin
        num_s[i+1]  <= take ? QR_W'(SQ1_W'(num_s[i]) - trial) : num_s[i];
        res_s[i+1]  <= take ? QR_W'((SQ1_W'(res_s[i]) >> 1) + bitv) : (res_s[i] >> 1);
        sovf_s[i+1] <= sovf_s[i];
      end
    end
  end

  // largest k with (2k-1)^2 <= q is (root + 1) / 2
  assign half_k = SR_W'(({1'b0, res_s[SR_W][SR_W-1:0]} + (SR_W+1)'(1)) >> 1);

  always_ff @(posedge clk) begin
    if (en) begin
      sat    <= sovf_s[SR_W] || half_k[OUT_W];
      radius <= (sovf_s[SR_W] || half_k[OUT_W]) ? '1 : half_k[OUT_W-1:0];
    end
  end
endmodule
`default_nettype wire

// File: rtl/three_point_circle_fit.sv
`default_nettype none
// channel  | dir | contents
// ---------+-----+------------------------------------------------------
// points   | in  | three pixel points a, b, c (x and y, 12 bits each)
// result   | out | center x/y (signed), radius, fit status
//
// one request per cycle while the skid is empty; at the default sizes the path
// is 7 front stages, 65 in the radius unit and one output register
// the radius unit's 42 divide and 21 root stages set the latency
// rst clears valid bits and the output/skid flags only
// a stalled result goes to a one-entry skid; the pipeline halts while it is full
`include "assert_macros.svh"
module three_point_circle_fit (
  input  logic        clk,
  input  logic        rst,
  tpcf_pt_if.sink     points,
  tpcf_res_if.source  result
);
  localparam int C      = tpcf_pkg::COORD_BITS;
  localparam int F      = tpcf_pkg::FRAC_BITS;
  localparam int OUT_W  = tpcf_pkg::OUT_W;
  localparam int DIF_W  = tpcf_pkg::DIF_W;
  localparam int DET_W  = tpcf_pkg::DET_W;
  localparam int SS_W   = tpcf_pkg::SS_W;
  localparam int ADET_W = tpcf_pkg::ADET_W;
  localparam int NX_W   = tpcf_pkg::NX_W;
  localparam int ANX_W  = tpcf_pkg::ANX_W;
  localparam int CD_W   = tpcf_pkg::CD_W;
  localparam int CE_W   = tpcf_pkg::CE_W;
  localparam int P_W    = tpcf_pkg::P_W;
  localparam int PL_W   = tpcf_pkg::PL_W;
  localparam int ML_W   = tpcf_pkg::ML_W;
  localparam int MH_W   = tpcf_pkg::MH_W;
  localparam int X_W    = tpcf_pkg::X_W;
  localparam int D2_W   = tpcf_pkg::D2_W;
  localparam int QC_W   = tpcf_pkg::QC_W;
  localparam int FRONT  = tpcf_pkg::FRONT;
  localparam int RAD_LAT = tpcf_pkg::RAD_LAT;
  localparam int CDLY   = tpcf_pkg::CDLY;
  localparam int DW2    = 2 * DET_W;
  localparam int SC_W   = QC_W + 2;
  localparam logic signed [SC_W-1:0] CMAX = SC_W'(2 ** (OUT_W - 1) - 1);
  localparam logic signed [SC_W-1:0] CMIN = -SC_W'(2 ** (OUT_W - 1));

  typedef struct packed {
    logic         coin;
    logic         colin;
    logic         negx;
    logic         negy;
    logic [C-1:0] ax;
    logic [C-1:0] ay;
  } side_t;

  typedef struct packed {
    logic [QC_W-1:0] qx;
    logic [QC_W-1:0] qy;
    logic            ox;
    logic            oy;
  } cq_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] cx;
    logic signed [OUT_W-1:0] cy;
    logic [OUT_W-1:0]        rad;
    tpcf_pkg::fit_status_t   st;
  } res_t;

  logic en;
  logic [FRONT-1:0] fv;
  side_t s1, s2, s3, s4, s5, s6, s7;

  logic [C-1:0] bx1, by1, cx1, cy1;
  logic signed [DIF_W-1:0] dbx2, dby2, dcx2, dcy2, ebx2, eby2;
  logic signed [DIF_W-1:0] dbx3, dby3, dcx3, dcy3;
  logic signed [DET_W-1:0] pbc3, pbd3;
  logic [SS_W-1:0] sqbx3, sqby3, sqcx3, sqcy3, sqex3, sqey3;
  logic signed [DIF_W-1:0] dbx4, dby4, dcx4, dcy4;
  logic signed [DET_W-1:0] det4;
  logic [SS_W-1:0] sb4, sc4, sbc4;
  logic signed [NX_W-1:0] pa5, pb5, pc5, pd5;
  logic [P_W-1:0] sbsc5;
  logic [SS_W-1:0] sbc5;
  logic [ADET_W-1:0] adet5, adet6;
  logic [D2_W-1:0] det2_5, det2_6, det2_7;
  logic dneg5, dneg6;
  logic signed [NX_W-1:0] nx6, ny6;
  logic [ML_W-1:0] mlo6;
  logic [MH_W-1:0] mhi6;
  logic [ANX_W-1:0] anx6, any6;
  logic [CD_W-1:0] cnx7, cny7;
  logic [CE_W-1:0] ce7;
  logic [X_W-1:0] x7;

  logic [QC_W-1:0] qx_u, qy_u;
  logic ox_u, oy_u;
  logic [OUT_W-1:0] rad_u;
  logic rsat_u;

  side_t sdl [RAD_LAT];
  logic [RAD_LAT-1:0] vdl;
  cq_t cdl [CDLY];

  side_t sd;
  cq_t cq;
  logic signed [QC_W:0] offx, offy;
  logic signed [SC_W-1:0] axs, ays, sumx, sumy;
  logic signed [OUT_W-1:0] cxv, cyv;
  logic satx, saty;
  res_t fin;

  logic pipe_v, out_v, skid_full, out_fire;
  res_t out_r, skid_r;

  assign en = !skid_full;
  assign points.ready = en;

  // valid bits through the front stages
  always_ff @(posedge clk) begin
    if (rst) begin
      fv <= '0;
    end else if (en) begin
      fv <= {fv[FRONT-2:0], points.valid};
    end
  end

  // stage 1: capture coordinates
  always_ff @(posedge clk) begin
    if (en) begin
      s1.coin  <= 1'b0;
      s1.colin <= 1'b0;
      s1.negx  <= 1'b0;
      s1.negy  <= 1'b0;
      s1.ax    <= C'(points.point_a_x);
      s1.ay    <= C'(points.point_a_y);
      bx1      <= C'(points.point_b_x);
      by1      <= C'(points.point_b_y);
      cx1      <= C'(points.point_c_x);
      cy1      <= C'(points.point_c_y);
    end
  end

  // stage 2: chord vectors and coincidence
  always_ff @(posedge clk) begin
    if (en) begin
      s2      <= s1;
      s2.coin <= (s1.ax == bx1 && s1.ay == by1) || (s1.ax == cx1 && s1.ay == cy1) ||
                 (bx1 == cx1 && by1 == cy1);
      dbx2    <= $signed({1'b0, bx1}) - $signed({1'b0, s1.ax});
      dby2    <= $signed({1'b0, by1}) - $signed({1'b0, s1.ay});
      dcx2    <= $signed({1'b0, cx1}) - $signed({1'b0, s1.ax});
      dcy2    <= $signed({1'b0, cy1}) - $signed({1'b0, s1.ay});
      ebx2    <= $signed({1'b0, cx1}) - $signed({1'b0, bx1});
      eby2    <= $signed({1'b0, cy1}) - $signed({1'b0, by1});
    end
  end

  // stage 3: cross terms and squares
  always_ff @(posedge clk) begin
    if (en) begin
      s3    <= s2;
      dbx3  <= dbx2;
      dby3  <= dby2;
      dcx3  <= dcx2;
      dcy3  <= dcy2;
      pbc3  <= DET_W'(dbx2) * DET_W'(dcy2);
      pbd3  <= DET_W'(dby2) * DET_W'(dcx2);
      sqbx3 <= SS_W'(DET_W'(dbx2) * DET_W'(dbx2));
      sqby3 <= SS_W'(DET_W'(dby2) * DET_W'(dby2));
      sqcx3 <= SS_W'(DET_W'(dcx2) * DET_W'(dcx2));
      sqcy3 <= SS_W'(DET_W'(dcy2) * DET_W'(dcy2));
      sqex3 <= SS_W'(DET_W'(ebx2) * DET_W'(ebx2));
      sqey3 <= SS_W'(DET_W'(eby2) * DET_W'(eby2));
    end
  end

  // stage 4: determinant and squared chord lengths
  always_ff @(posedge clk) begin
    if (en) begin
      s4   <= s3;
      dbx4 <= dbx3;
      dby4 <= dby3;
      dcx4 <= dcx3;
      dcy4 <= dcy3;
      det4 <= pbc3 - pbd3;
      sb4  <= sqbx3 + sqby3;
      sc4  <= sqcx3 + sqcy3;
      sbc4 <= sqex3 + sqey3;
    end
  end

  // stage 5: numerator terms, length product, det squared
  always_ff @(posedge clk) begin
    if (en) begin
      s5       <= s4;
      s5.colin <= (det4 == '0);
      pa5      <= NX_W'(dcy4) * NX_W'($signed({1'b0, sb4}));
      pb5      <= NX_W'(dby4) * NX_W'($signed({1'b0, sc4}));
      pc5      <= NX_W'(dbx4) * NX_W'($signed({1'b0, sc4}));
      pd5      <= NX_W'(dcx4) * NX_W'($signed({1'b0, sb4}));
      sbsc5    <= P_W'(sb4) * P_W'(sc4);
      sbc5     <= sbc4;
      adet5    <= ADET_W'(det4[DET_W-1] ? -det4 : det4);
      det2_5   <= D2_W'(DW2'(det4) * DW2'(det4));
      dneg5    <= det4[DET_W-1];
    end
  end

  // stage 6: center numerators, split product of three lengths
  always_ff @(posedge clk) begin
    if (en) begin
      s6     <= s5;
      nx6    <= pa5 - pb5;
      ny6    <= pc5 - pd5;
      mlo6   <= ML_W'(sbsc5[PL_W-1:0]) * ML_W'(sbc5);
      mhi6   <= MH_W'(sbsc5[P_W-1:PL_W]) * MH_W'(sbc5);
      adet6  <= adet5;
      det2_6 <= det2_5;
      dneg6  <= dneg5;
    end
  end

  assign anx6 = ANX_W'(nx6[NX_W-1] ? -nx6 : nx6);
  assign any6 = ANX_W'(ny6[NX_W-1] ? -ny6 : ny6);

  // stage 7: rounded dividends, radius numerator
  always_ff @(posedge clk) begin
    if (en) begin
      s7      <= s6;
      s7.negx <= nx6[NX_W-1] ^ dneg6;
      s7.negy <= ny6[NX_W-1] ^ dneg6;
      cnx7    <= (CD_W'(anx6) << F) + CD_W'(adet6);
      cny7    <= (CD_W'(any6) << F) + CD_W'(adet6);
      ce7     <= {adet6, 1'b0};
      x7      <= (X_W'(mhi6) << (PL_W + 2 * F)) + (X_W'(mlo6) << (2 * F));
      det2_7  <= det2_6;
    end
  end

  tpcf_cdiv u_div_x (
    .clk (clk),
    .en  (en),
    .num (cnx7),
    .den (ce7),
    .quo (qx_u),
    .ovf (ox_u)
  );

  tpcf_cdiv u_div_y (
    .clk (clk),
    .en  (en),
    .num (cny7),
    .den (ce7),
    .quo (qy_u),
    .ovf (oy_u)
  );

  tpcf_rad u_rad (
    .clk    (clk),
    .en     (en),
    .x      (x7),
    .det2   (det2_7),
    .radius (rad_u),
    .sat    (rsat_u)
  );

  // side data follows the radius unit
  always_ff @(posedge clk) begin
    if (en) begin
      sdl[0] <= s7;
      for (int i = 1; i < RAD_LAT; i++) begin
        sdl[i] <= sdl[i-1];
      end
      cdl[0] <= '{qx: qx_u, qy: qy_u, ox: ox_u, oy: oy_u};
      for (int i = 1; i < CDLY; i++) begin
        cdl[i] <= cdl[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vdl <= '0;
    end else if (en) begin
      vdl <= {vdl[RAD_LAT-2:0], fv[FRONT-1]};
    end
  end

  assign pipe_v = vdl[RAD_LAT-1];
  assign sd     = sdl[RAD_LAT-1];
  assign cq     = cdl[CDLY-1];

  // signed offset added to point a, then clamp
  always_comb begin
    offx = sd.negx ? -$signed({1'b0, cq.qx}) : $signed({1'b0, cq.qx});
    offy = sd.negy ? -$signed({1'b0, cq.qy}) : $signed({1'b0, cq.qy});
    axs  = $signed(SC_W'({1'b0, sd.ax})) << F;
    ays  = $signed(SC_W'({1'b0, sd.ay})) << F;
    sumx = axs + SC_W'(offx);
    sumy = ays + SC_W'(offy);
    satx = cq.ox || sumx > CMAX || sumx < CMIN;
    saty = cq.oy || sumy > CMAX || sumy < CMIN;
    if (cq.ox) begin
      cxv = sd.negx ? OUT_W'(CMIN) : OUT_W'(CMAX);
    end else if (sumx > CMAX) begin
      cxv = OUT_W'(CMAX);
    end else if (sumx < CMIN) begin
      cxv = OUT_W'(CMIN);
    end else begin
      cxv = OUT_W'(sumx);
    end
    if (cq.oy) begin
      cyv = sd.negy ? OUT_W'(CMIN) : OUT_W'(CMAX);
    end else if (sumy > CMAX) begin
      cyv = OUT_W'(CMAX);
    end else if (sumy < CMIN) begin
      cyv = OUT_W'(CMIN);
    end else begin
      cyv = OUT_W'(sumy);
    end
  end

  // status priority: coincident, collinear, saturated
  always_comb begin
    fin.cx  = cxv;
    fin.cy  = cyv;
    fin.rad = rad_u;
    priority if (sd.coin) begin
      fin = '{cx: '0, cy: '0, rad: '0, st: tpcf_pkg::ST_COINCIDE};
    end else if (sd.colin) begin
      fin = '{cx: '0, cy: '0, rad: '0, st: tpcf_pkg::ST_COLLINEAR};
    end else if (satx || saty || rsat_u) begin
      fin.st = tpcf_pkg::ST_SATURATED;
    end else begin
      fin.st = tpcf_pkg::ST_OK;
    end
  end

  assign out_fire = out_v && result.ready;

  // output register and skid flags
  always_ff @(posedge clk) begin
    if (rst) begin
      out_v     <= 1'b0;
      skid_full <= 1'b0;
    end else begin
      priority if (skid_full) begin
        if (out_fire) begin
          skid_full <= 1'b0;
        end
      end else if (pipe_v) begin
        if (out_v && !result.ready) begin
          skid_full <= 1'b1;
        end else begin
          out_v <= 1'b1;
        end
      end else if (out_fire) begin
        out_v <= 1'b0;
      end else begin
        // nothing moves
      end
    end
  end

  // output and skid payload
  always_ff @(posedge clk) begin
    priority if (skid_full) begin
      if (out_fire) begin
        out_r <= skid_r;
      end
    end else if (pipe_v) begin
      if (out_v && !result.ready) begin
        skid_r <= fin;
      end else begin
        out_r <= fin;
      end
    end else begin
      // hold payload
    end
  end

  assign result.valid         = out_v;
  assign result.center_x      = out_r.cx;
  assign result.center_y      = out_r.cy;
  assign result.circle_radius = out_r.rad;
  assign result.fit_status    = out_r.st;

  // checks
  `AST_RST(a_skid_needs_out, clk, rst, skid_full |-> out_v, "skid full with no result pending")
  `AST_RST(a_reject_zero, clk, rst, (result.valid && (result.fit_status == tpcf_pkg::ST_COINCIDE || result.fit_status == tpcf_pkg::ST_COLLINEAR)) |-> (result.center_x == '0 && result.center_y == '0 && result.circle_radius == '0), "rejected triple with nonzero fields")
  `AST_RST(a_stall_holds, clk, rst, skid_full |=> $stable(vdl), "pipeline moved while stalled")

endmodule
`default_nettype wire
